@@ src/aesbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesbc_pkg
// Shared types, register indexes and GF(2^8) helpers for the AES core.
// ----------------------------------------------------------------------------
package aesbc_pkg;

   typedef enum logic [2:0] {
      CSR_KEY0     = 3'd0,
      CSR_KEY1     = 3'd1,
      CSR_KEY2     = 3'd2,
      CSR_KEY3     = 3'd3,
      CSR_KEY_SIZE = 3'd4,
      CSR_DECRYPT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KEY_SIZE_128 = 2'd0,
      KEY_SIZE_192 = 2'd1,
      KEY_SIZE_256 = 2'd2
   } key_size_type;

   typedef enum logic [2:0] {
      KX_CLEAR,
      KX_LOAD,
      KX_EXPAND,
      KX_INVMIX_RD,
      KX_INVMIX_WR,
      KX_DONE
   } kx_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_FIRST,
      CS_ROUND,
      CS_OUT
   } core_state_type;

   localparam logic [7:0] RCON_FIRST = 8'h01;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int k = 0; k < 4; k++) begin
         if (b[k]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   function automatic logic [7:0] gmul_full(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p = p ^ x;
         x = xtime(x);
      end
      gmul_full = p;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] inv;
      logic [7:0] pw;
      inv = 8'h01;
      pw = x;
      for (int k = 0; k < 7; k++) begin
         pw = gmul_full(pw, pw);
         inv = gmul_full(inv, pw);
      end
      if (x == 8'h00) inv = 8'h00;
      sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] s);
      logic [7:0] y;
      logic [7:0] inv;
      y = {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ 8'h05;
      inv = 8'h01;
      for (int k = 0; k < 7; k++) begin
         y = gmul_full(y, y);
         inv = gmul_full(inv, y);
      end
      if (({s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ 8'h05) == 8'h00)
         inv = 8'h00;
      inv_sbox = inv;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inverse);
      logic [7:0] a [4];
      logic [7:0] c [4];
      logic [3:0] m0, m1, m2, m3;
      for (int j = 0; j < 4; j++) a[j] = w[8*j +: 8];
      m0 = inverse ? 4'd14 : 4'd2;
      m1 = inverse ? 4'd11 : 4'd3;
      m2 = inverse ? 4'd13 : 4'd1;
      m3 = inverse ? 4'd9 : 4'd1;
      c[0] = gmul(a[0], m0) ^ gmul(a[1], m1) ^ gmul(a[2], m2) ^ gmul(a[3], m3);
      c[1] = gmul(a[0], m3) ^ gmul(a[1], m0) ^ gmul(a[2], m1) ^ gmul(a[3], m2);
      c[2] = gmul(a[0], m2) ^ gmul(a[1], m3) ^ gmul(a[2], m0) ^ gmul(a[3], m1);
      c[3] = gmul(a[0], m1) ^ gmul(a[1], m2) ^ gmul(a[2], m3) ^ gmul(a[3], m0);
      mix_col = {c[3], c[2], c[1], c[0]};
   endfunction

endpackage

@@ src/aesbc_key_expand.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesbc_key_expand
// Round key memory and word-serial key schedule sequencer.
// ----------------------------------------------------------------------------
module aesbc_key_expand #(
   parameter int unsigned WORDS = 60,
   parameter int unsigned AW    = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [255:0]           key,
   input  logic [1:0]             size_sel,
   input  logic                   decrypt,
   input  logic [AW-1:0]          rd_addr,
   output logic [127:0]           rd_data,
   output logic                   ready,
   output logic [3:0]             num_rounds
);
   import aesbc_pkg::*;

   localparam int unsigned ROWS = WORDS / 4;

   logic [127:0] mem [ROWS];
   logic [127:0] rd_data_ff;

   kx_state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic [3:0]    nk_ff, nk_in;
   logic [AW-1:0] total_ff, total_in;
   logic [3:0]    nr_ff, nr_in;
   logic [255:0]  win_ff, win_in;
   logic [127:0]  row_ff, row_in;

   logic          wr_en;
   logic [AW-3:0] wr_row;
   logic [127:0]  wr_data;
   logic [AW-3:0] mrd_row;
   logic [3:0]    sz_nr;
   logic [1:0]    sz;
   logic [31:0]   t_word;
   logic [31:0]   new_word;
   logic [31:0]   prev_word;
   logic [31:0]   back_word;

   always_comb begin
      sz = (size_sel == 2'd3) ? 2'd2 : size_sel;
      if (sz == 2'd2 && WORDS < 60) sz = 2'd1;
      if (sz == 2'd1 && WORDS < 52) sz = 2'd0;
      sz_nr = 4'd10 + {1'b0, sz, 1'b0};
   end

   // window holds the last nk words, newest at nk-1
   always_comb begin
      prev_word = win_ff[32*(nk_ff-4'd1) +: 32];
      back_word = win_ff[31:0];
      t_word = prev_word;
      if (rem_ff == '0) t_word = sub_word({prev_word[7:0], prev_word[31:8]}) ^ {24'h0, rcon_ff};
      else if (nk_ff == 4'd8 && rem_ff == AW'(4)) t_word = sub_word(prev_word);
      new_word = back_word ^ t_word;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      rcon_in  = rcon_ff;
      nk_in    = nk_ff;
      total_in = total_ff;
      nr_in    = nr_ff;
      win_in   = win_ff;
      row_in   = row_ff;
      wr_en    = 1'b0;
      wr_row   = idx_ff[AW-1:2];
      wr_data  = row_ff;
      mrd_row  = idx_ff[AW-1:2];
      unique case (state_ff)
         KX_CLEAR: state_in = KX_LOAD;
         KX_LOAD: begin
            nr_in    = sz_nr;
            nk_in    = 4'd4 + {1'b0, sz, 1'b0};
            total_in = AW'({sz_nr, 2'b00} + 6'd4);
            win_in   = key;
            idx_in   = '0;
            rem_in   = '0;
            rcon_in  = RCON_FIRST;
            state_in = KX_EXPAND;
         end
         KX_EXPAND: begin
            // first nk words come straight from the key, then one derived word per cycle
            if (idx_ff < AW'(nk_ff)) begin
               row_in[32*idx_ff[1:0] +: 32] = key[32*idx_ff +: 32];
            end else begin
               row_in[32*idx_ff[1:0] +: 32] = new_word;
               win_in = {32'h0, win_ff[255:32]};
               win_in[32*(nk_ff-4'd1) +: 32] = new_word;
               if (rem_ff == '0) rcon_in = xtime(rcon_ff);
               rem_in = (rem_ff == AW'(nk_ff) - AW'(1)) ? '0 : rem_ff + AW'(1);
            end
            if (idx_ff[1:0] == 2'd3) begin
               wr_en   = 1'b1;
               wr_data = row_in;
            end
            if (idx_ff == AW'(nk_ff) - AW'(1)) rem_in = '0;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == total_ff - AW'(1)) begin
               idx_in   = AW'(4);
               state_in = decrypt ? KX_INVMIX_RD : KX_DONE;
            end
         end
         KX_INVMIX_RD: state_in = KX_INVMIX_WR;
         KX_INVMIX_WR: begin
            wr_en  = 1'b1;
            for (int c = 0; c < 4; c++)
               wr_data[32*c +: 32] = mix_col(rd_data_ff[32*c +: 32], 1'b1);
            idx_in = idx_ff + AW'(4);
            state_in = (idx_ff + AW'(4) == AW'({nr_ff, 2'b00})) ? KX_DONE : KX_INVMIX_RD;
         end
         KX_DONE: ;
         default: state_in = KX_CLEAR;
      endcase
      if (start) state_in = KX_LOAD;
      if (state_ff == KX_DONE) mrd_row = rd_addr[AW-1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KX_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      idx_ff   <= idx_in;
      rem_ff   <= rem_in;
      rcon_ff  <= rcon_in;
      nk_ff    <= nk_in;
      total_ff <= total_in;
      nr_ff    <= nr_in;
      win_ff   <= win_in;
      row_ff   <= row_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_row] <= wr_data;
      rd_data_ff <= mem[mrd_row];
   end

   assign rd_data    = rd_data_ff;
   assign ready      = (state_ff == KX_DONE) && !start;
   assign num_rounds = nr_ff;
endmodule

@@ src/aesbc_round_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesbc_round_core
// Iterative AES round datapath, one round per cycle.
// ----------------------------------------------------------------------------
module aesbc_round_core #(
   parameter int unsigned AW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [127:0]  in_block,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [127:0]  out_block,
   input  logic          keys_ready,
   input  logic          decrypt,
   input  logic [3:0]    num_rounds,
   output logic [AW-1:0] key_addr,
   input  logic [127:0]  key_row
);
   import aesbc_pkg::*;

   core_state_type state_ff, state_in;
   logic [127:0] st_ff, st_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] sr;
   logic [127:0] mixed;
   logic         last;

   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (decrypt)
               sr[8*(4*((c+r)%4)+r) +: 8] = inv_sbox(st_ff[8*(4*c+r) +: 8]);
            else
               sr[8*(4*c+r) +: 8] = sbox(st_ff[8*(4*((c+r)%4)+r) +: 8]);
         end
      for (int c = 0; c < 4; c++)
         mixed[32*c +: 32] = mix_col(sr[32*c +: 32], decrypt);
   end

   // round counter counts applied rounds; key row follows direction
   always_comb begin
      logic [3:0] kr;
      kr = decrypt ? (num_rounds - rnd_in) : rnd_in;
      key_addr = AW'({kr, 2'b00});
   end

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      rnd_in   = rnd_ff;
      last     = (rnd_ff == num_rounds);
      unique case (state_ff)
         CS_IDLE: begin
            rnd_in = '0;
            if (in_valid && keys_ready) begin
               st_in    = in_block;
               state_in = CS_FIRST;
            end
         end
         CS_FIRST: begin
            st_in    = st_ff ^ key_row;
            rnd_in   = 4'd1;
            state_in = CS_ROUND;
         end
         CS_ROUND: begin
            st_in  = (last ? sr : mixed) ^ key_row;
            rnd_in = rnd_ff + 4'd1;
            if (last) state_in = CS_OUT;
         end
         CS_OUT: begin
            rnd_in = '0;
            if (out_ready) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
      st_ff <= st_in;
   end

   assign in_ready  = (state_ff == CS_IDLE) && keys_ready;
   assign out_valid = (state_ff == CS_OUT);
   assign out_block = st_ff;
endmodule

@@ src/aes_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 ECB block cipher with stored round key schedule.
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes key words, key size and direction; each such write restarts
//   the key expansion, which fills the round key memory one word a cycle,
//   then for decryption rewrites the inner rows through InvMixColumns.
//   req_tready stays low until the schedule is complete.
//   req_tdata carries one 16-byte block, rsp_tdata the result.
//   After a request is taken, the core does the initial key add, then one
//   round per cycle, each with one key row read from the round key memory,
//   and then raises rsp_tvalid. One block is in flight at a time; a held
//   rsp_tvalid stalls the core, and req_tready stays low until the result
//   is taken.
//   Reset clears the registers and expands the all-zero 128-bit key.
// ----------------------------------------------------------------------------
module aes_block_cipher #(
   parameter int unsigned ROUND_KEY_WORDS = 60
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_low, block_high
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_low, out_high
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import aesbc_pkg::*;

   localparam int unsigned AW = $clog2(ROUND_KEY_WORDS);

   logic [255:0] key_ff, key_in;
   logic [1:0]   size_ff, size_in;
   logic         dec_ff, dec_in;
   logic         start;
   logic [AW-1:0] key_addr;
   logic [127:0] key_row;
   logic         keys_ready;
   logic [3:0]   num_rounds;

   always_comb begin
      key_in  = key_ff;
      size_in = size_ff;
      dec_in  = dec_ff;
      start   = csr_we;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY0:     key_in[63:0]    = csr_wdata;
            CSR_KEY1:     key_in[127:64]  = csr_wdata;
            CSR_KEY2:     key_in[191:128] = csr_wdata;
            CSR_KEY3:     key_in[255:192] = csr_wdata;
            CSR_KEY_SIZE: size_in = csr_wdata[1:0];
            CSR_DECRYPT:  dec_in  = csr_wdata[0];
            default:      start   = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         size_ff <= KEY_SIZE_128;
         dec_ff  <= 1'b0;
      end else begin
         key_ff  <= key_in;
         size_ff <= size_in;
         dec_ff  <= dec_in;
      end
   end

   aesbc_key_expand #(.WORDS(ROUND_KEY_WORDS), .AW(AW)) u_key (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .key        (key_ff),
      .size_sel   (size_ff),
      .decrypt    (dec_ff),
      .rd_addr    (key_addr),
      .rd_data    (key_row),
      .ready      (keys_ready),
      .num_rounds (num_rounds)
   );

   aesbc_round_core #(.AW(AW)) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_block   (req_tdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_block  (rsp_tdata),
      .keys_ready (keys_ready),
      .decrypt    (dec_ff),
      .num_rounds (num_rounds),
      .key_addr   (key_addr),
      .key_row    (key_row)
   );

`ifndef ASSERT_OFF
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");
   a_rounds_legal: assert property (@(posedge clock) disable iff (reset)
      keys_ready |-> (num_rounds == 4'd10 || num_rounds == 4'd12 || num_rounds == 4'd14))
      else $error("bad round count");
   a_accept_needs_keys: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> keys_ready) else $error("request before schedule");
`endif
endmodule

@@ sim/aes_block_cipher_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_check
// Watches the request, response and register ports of the AES core, keeps
// its own key schedule, predicts each ciphered block and compares.
// ----------------------------------------------------------------------------
module aes_block_cipher_check (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output int           pending,
   output int           errors
);
   import aesbc_pkg::*;

   logic [7:0]   fwd_sub [256];
   logic [7:0]   inv_sub [256];
   logic [63:0]  key_word [4];
   logic [1:0]   key_len;
   logic         decrypting;
   logic [31:0]  sched [60];
   int           rounds;
   int           fail_count;
   logic [127:0] expected_blocks [$];

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [31:0] col_mix(input logic [31:0] w, input logic inverse);
      logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
      a0 = w[7:0];
      a1 = w[15:8];
      a2 = w[23:16];
      a3 = w[31:24];
      m0 = inverse ? 8'd14 : 8'd2;
      m1 = inverse ? 8'd11 : 8'd3;
      m2 = inverse ? 8'd13 : 8'd1;
      m3 = inverse ? 8'd9 : 8'd1;
      return {gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0),
              gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1),
              gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2),
              gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3)};
   endfunction

   function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
      return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
   endfunction

   function automatic void rebuild_schedule();
      int sz, nk, total;
      logic [7:0] kb [32];
      logic [7:0] rcon;
      logic [31:0] t;
      sz = (key_len == 2'd3) ? 2 : int'(key_len);
      while (sz > 0 && 4 * (11 + 2 * sz) > 60) sz--;
      rounds = 10 + 2 * sz;
      nk = 4 + 2 * sz;
      total = 4 * (rounds + 1);
      rcon = 8'h01;
      for (int i = 0; i < 32; i++) kb[i] = key_word[i >> 3][8 * (i & 7) +: 8];
      for (int i = 0; i < nk; i++)
         sched[i] = {kb[4 * i + 3], kb[4 * i + 2], kb[4 * i + 1], kb[4 * i]};
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = sub_bytes32({t[7:0], t[31:8]}) ^ {24'h0, rcon};
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_bytes32(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
      if (decrypting)
         for (int j = 4; j < 4 * rounds; j++) sched[j] = col_mix(sched[j], 1'b1);
   endfunction

   function automatic logic [127:0] key_add(input logic [127:0] v, input int r);
      for (int c = 0; c < 4; c++) v[32 * c +: 32] ^= sched[4 * r + c];
      return v;
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] v, input logic inverse);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (inverse)
               t[8 * (4 * ((c + r) & 3) + r) +: 8] = inv_sub[v[8 * (4 * c + r) +: 8]];
            else
               t[8 * (4 * c + r) +: 8] = fwd_sub[v[8 * (4 * ((c + r) & 3) + r) +: 8]];
         end
      return t;
   endfunction

   function automatic logic [127:0] mix_all(input logic [127:0] v, input logic inverse);
      for (int c = 0; c < 4; c++) v[32 * c +: 32] = col_mix(v[32 * c +: 32], inverse);
      return v;
   endfunction

   function automatic logic [127:0] cipher_block(input logic [127:0] v);
      if (!decrypting) begin
         v = key_add(v, 0);
         for (int r = 1; r < rounds; r++) v = key_add(mix_all(sub_shift(v, 1'b0), 1'b0), r);
         v = key_add(sub_shift(v, 1'b0), rounds);
      end else begin
         v = key_add(v, rounds);
         for (int r = rounds - 1; r >= 1; r--)
            v = key_add(mix_all(sub_shift(v, 1'b1), 1'b1), r);
         v = key_add(sub_shift(v, 1'b1), 0);
      end
      return v;
   endfunction

   initial begin
      logic [7:0] inv, pw, s;
      fail_count = 0;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         pw = x[7:0];
         for (int k = 0; k < 7; k++) begin
            pw = gf_mul(pw, pw);
            inv = gf_mul(inv, pw);
         end
         if (x == 0) inv = 8'h00;
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_sub[x] = s;
         inv_sub[s] = x[7:0];
      end
   end

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_word[i] = 64'h0;
         key_len = 2'd0;
         decrypting = 1'b0;
         rebuild_schedule();
         expected_blocks.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY0:     key_word[0] = csr_wdata;
               CSR_KEY1:     key_word[1] = csr_wdata;
               CSR_KEY2:     key_word[2] = csr_wdata;
               CSR_KEY3:     key_word[3] = csr_wdata;
               CSR_KEY_SIZE: key_len = csr_wdata[1:0];
               CSR_DECRYPT:  decrypting = csr_wdata[0];
               default:      ;
            endcase
            if (csr_index <= CSR_DECRYPT) rebuild_schedule();
         end
         if (req_tvalid && req_tready) expected_blocks.push_back(cipher_block(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata[63:0] !== want[63:0]) begin
                  fail_count++;
                  $display("%0t: out_low expected %h actual %h",
                           $time, want[63:0], rsp_tdata[63:0]);
               end
               if (rsp_tdata[127:64] !== want[127:64]) begin
                  fail_count++;
                  $display("%0t: out_high expected %h actual %h",
                           $time, want[127:64], rsp_tdata[127:64]);
               end
            end
         end
      end
      pending <= expected_blocks.size();
      errors <= fail_count;
   end

endmodule

@@ sim/aes_block_cipher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_test
// Runs the AES core through key sizes, directions and keys with directed
// and random blocks under random back-pressure; the checker scores it.
// ----------------------------------------------------------------------------
module aes_block_cipher_test;
   import aesbc_pkg::*;

   localparam logic [2:0] CSR_SPARE6 = 3'd6;
   localparam logic [2:0] CSR_SPARE7 = 3'd7;
   localparam logic [1:0] KEY_SIZE_ODD = 2'd3;
   localparam int STALL_LIMIT = 5000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;
   int           pending;
   int           errors;
   int           send_idle;
   int           recv_idle;
   int           hold_left;
   int           blocks_sent;
   int           stall_cycles;

   aes_block_cipher dut (.*);

   aes_block_cipher_check checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
      int gap;
      if (blocks_sent == 200) begin
         send_idle = 54;
         recv_idle = 27;
      end else if (blocks_sent == 400) begin
         send_idle = 0;
         recv_idle = 0;
      end
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {hi, lo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blocks_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [63:0] k [4];
      logic [1:0]  ksize;
      logic        dir;
      logic [63:0] lo, hi;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_KEY0;
      csr_wdata <= '0;
      send_idle = 27;
      recv_idle = 54;
      hold_left = 0;
      blocks_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int s = 0; s < 8; s++) begin
         if (s > 0) begin
            case (s)
               1: begin
                  for (int i = 0; i < 4; i++) k[i] = '1;
                  ksize = KEY_SIZE_128; dir = 1'b0;
               end
               2: begin
                  k[0] = 64'h0706050403020100; k[1] = 64'h0f0e0d0c0b0a0908;
                  k[2] = 64'h1716151413121110; k[3] = 64'h1f1e1d1c1b1a1918;
                  ksize = KEY_SIZE_256; dir = 1'b1;
               end
               3: begin
                  for (int i = 0; i < 4; i++) k[i] = rand64();
                  ksize = KEY_SIZE_ODD; dir = 1'b0;
               end
               4: begin
                  k[0] = 64'h0706050403020100; k[1] = 64'h0f0e0d0c0b0a0908;
                  k[2] = 64'h1716151413121110; k[3] = '0;
                  ksize = KEY_SIZE_192; dir = 1'b1;
               end
               5: begin
                  for (int i = 0; i < 4; i++) k[i] = rand64();
                  ksize = KEY_SIZE_128; dir = 1'b1;
               end
               6: begin
                  for (int i = 0; i < 4; i++) k[i] = '1;
                  ksize = KEY_SIZE_256; dir = 1'b0;
               end
               default: begin
                  for (int i = 0; i < 4; i++) k[i] = rand64();
                  ksize = 2'($urandom_range(3)); dir = 1'($urandom_range(1));
               end
            endcase
            write_reg(CSR_KEY0, k[0]);
            write_reg(CSR_KEY1, k[1]);
            write_reg(CSR_KEY2, k[2]);
            write_reg(CSR_KEY3, k[3]);
            write_reg(CSR_KEY_SIZE, {62'h0, ksize});
            write_reg(CSR_DECRYPT, {63'h0, dir});
            write_reg(CSR_SPARE6, rand64());
            write_reg(CSR_SPARE7, rand64());
         end
         send_block('0, '0);
         send_block('1, '1);
         send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
         if (s == 2) hold_left = 400;
         for (int n = 0; n < 72; n++) begin
            lo = rand64();
            hi = rand64();
            case ($urandom_range(15))
               0: lo = '0;
               1: hi = '1;
               default: ;
            endcase
            send_block(lo, hi);
         end
         drain();
      end
      $display("Ran %0d blocks over reset, 128/192/256-bit and odd key sizes,", blocks_sent);
      $display("both directions, ignored register indexes and back-pressure.");
      if (errors == 0 && pending == 0)
         $display("[aes_block_cipher] OK");
      else
         $display("[aes_block_cipher] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[aes_block_cipher] ERROR");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
src/aesbc_pkg.sv
src/aesbc_key_expand.sv
src/aesbc_round_core.sv
src/aes_block_cipher.sv
sim/aes_block_cipher_check.sv
sim/aes_block_cipher_test.sv
